// File: src/svmm_pkg.sv
//------------------------------------------------------------------------------
// Sparse vector-matrix multiply package
// Field widths, request codes, controller states and the command and status
// records exchanged between the controller and the datapath.
//------------------------------------------------------------------------------
package svmm_pkg;

  localparam int REQ_W   = 3;
  localparam int COL_W   = 10;
  localparam int VAL_W   = 32;
  localparam int ROW_W   = 16;
  localparam int CNT_W   = 17;
  localparam int IDX_W   = 17;   // Holds any store depth up to 131071.
  localparam int EPOCH_W = 4;

  localparam int DEF_MAX_COLUMNS = 1024;

  localparam logic [CNT_W-1:0]   COUNT_MAX  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_VECTOR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MATRIX  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ROW_END = 3'd3;
  localparam logic [REQ_W-1:0] REQ_JOB_END = 3'd4;

  // Result kinds.
  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_JOB = 1'b1;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROW,
    ST_JOB
  } state_t;

  typedef struct packed {
    logic sweep_wr;   // Write an empty tag at the sweep address.
    logic clear;      // Start a new job.
    logic vec_wr;     // Store the incoming vector entry.
    logic load;       // Capture the incoming matrix entry.
    logic mul;        // Form the product with the stored vector value.
    logic acc_add;    // Add the product to the accumulator.
    logic row_done;   // Clear the accumulator and advance the row counter.
    logic emit_row;   // Load a row result into the output register.
    logic emit_job;   // Load a job status result into the output register.
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;   // The output register can take a result this cycle.
    logic acc_nz;     // The accumulator is nonzero.
    logic epoch_last; // The job tag is about to wrap.
    logic sweep_last; // The sweep is at the last store entry.
  } dp_status_t;

endpackage

// File: src/svmm_if.sv
//------------------------------------------------------------------------------
// Sparse vector-matrix multiply channels
// Valid/ready channels for the request stream and the result stream.
//------------------------------------------------------------------------------
interface svmm_in_if;
  import svmm_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [COL_W-1:0]   column;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output req_type, output column, output value,
                  input ready);
  modport sink   (input valid, input req_type, input column, input value,
                  output ready);
endinterface

interface svmm_out_if;
  import svmm_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [ROW_W-1:0]   row_index;
  logic signed [VAL_W-1:0] sum;
  logic               status;
  logic [CNT_W-1:0]   result_count;

  modport source (output valid, output kind, output row_index, output sum,
                  output status, output result_count, input ready);
  modport sink   (input valid, input kind, input row_index, input sum,
                  input status, input result_count, output ready);
endinterface

// File: src/sparse_vector_matrix_multiply_unit.sv
//------------------------------------------------------------------------------
// Sparse vector-matrix multiply unit
// Sparse row vector times a transposed sparse matrix streamed in row order.
//------------------------------------------------------------------------------
//  Channel   Direction  Handshake     Contents
//  in_chan   sink       valid/ready   req_type, column, value
//  out_chan  source     valid/ready   kind, row_index, sum, status, result_count
//
//  Each matrix entry passes through store read, multiply and accumulate. A
//  job end, or a row end with a nonzero sum, waits while the output register
//  still holds an unaccepted result; a row with a zero sum gives no result.
//  After reset, and on every fifteenth clear when the job tag wraps, the store
//  is swept with the input held off.
//  The output register lets the next request enter while a result waits.
//------------------------------------------------------------------------------
module sparse_vector_matrix_multiply_unit #(
  parameter int MAX_COLUMNS = svmm_pkg::DEF_MAX_COLUMNS
) (
  input  logic        clk,
  input  logic        rst_n,
  svmm_in_if.sink     in_chan,
  svmm_out_if.source  out_chan
);
  import svmm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller decodes each request and steps through the multiply and
  // result hand-off; the datapath holds the vector store and all counters.
  svmm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_ready    (in_chan.ready),
    .status      (status),
    .cmd         (cmd)
  );

  svmm_dp #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_column        (in_chan.column),
    .in_value         (in_chan.value),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_kind         (out_chan.kind),
    .out_row_index    (out_chan.row_index),
    .out_sum          (out_chan.sum),
    .out_status       (out_chan.status),
    .out_result_count (out_chan.result_count)
  );

endmodule

// File: src/svmm_ram.sv
//------------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
//------------------------------------------------------------------------------
module svmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/svmm_ctrl.sv
//------------------------------------------------------------------------------
// Sparse vector-matrix multiply controller
// Sequences the store sweep, request decoding and result hand-off.
//------------------------------------------------------------------------------
module svmm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [svmm_pkg::REQ_W-1:0] in_req_type,
  output logic                   in_ready,
  input  svmm_pkg::dp_status_t   status,
  output svmm_pkg::ctrl_cmd_t    cmd
);
  import svmm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_req_type)
            REQ_CLEAR: begin
              cmd.clear = 1'b1;
              // The tag space is used up, so old entries must be wiped.
              if (status.epoch_last) begin
                state_nxt = ST_SWEEP;
              end
            end
            REQ_VECTOR: begin
              cmd.vec_wr = 1'b1;
            end
            REQ_MATRIX: begin
              cmd.load  = 1'b1;
              state_nxt = ST_MUL;
            end
            REQ_ROW_END: begin
              state_nxt = ST_ROW;
            end
            REQ_JOB_END: begin
              state_nxt = ST_JOB;
            end
            default: begin
              // Unused codes are dropped.
            end
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_ROW: begin
        if (!status.acc_nz) begin
          cmd.row_done = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (status.out_free) begin
          cmd.row_done = 1'b1;
          cmd.emit_row = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_JOB: begin
        if (status.out_free) begin
          cmd.emit_job = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_SWEEP;
      end
    endcase
  end

endmodule

// File: src/svmm_dp.sv
//------------------------------------------------------------------------------
// Sparse vector-matrix multiply datapath
// Vector store with job tags, multiply-accumulate, counters and result register.
//------------------------------------------------------------------------------
module svmm_dp #(
  parameter int MAX_COLUMNS = svmm_pkg::DEF_MAX_COLUMNS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  svmm_pkg::ctrl_cmd_t            cmd,
  output svmm_pkg::dp_status_t           status,
  input  logic [svmm_pkg::COL_W-1:0]     in_column,
  input  logic signed [svmm_pkg::VAL_W-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic [svmm_pkg::ROW_W-1:0]     out_row_index,
  output logic signed [svmm_pkg::VAL_W-1:0] out_sum,
  output logic                           out_status,
  output logic [svmm_pkg::CNT_W-1:0]     out_result_count
);
  import svmm_pkg::*;

  localparam int AW     = $clog2(MAX_COLUMNS);
  localparam int WORD_W = EPOCH_W + VAL_W;

  // Store word: job tag in the upper bits, vector value below.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [IDX_W-1:0]   col_ext;
  logic               col_ok;
  logic [AW-1:0]      col_addr;

  logic [AW-1:0]      sweep_addr_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [VAL_W-1:0]   value_r;
  logic               col_ok_r;
  logic [VAL_W-1:0]   prod_r;
  logic [VAL_W-1:0]   acc_r;
  logic [ROW_W-1:0]   row_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_inc;
  logic               hit;
  logic [VAL_W-1:0]   product;
  logic               out_valid_r;

  assign col_ext  = IDX_W'(in_column);
  assign col_ok   = (col_ext < IDX_W'(MAX_COLUMNS));
  assign col_addr = col_ext[AW-1:0];

  always_comb begin
    if (cmd.sweep_wr) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.vec_wr && col_ok;
      ram_waddr = col_addr;
      ram_wdata = {epoch_r, in_value};
    end
  end

  assign ram_raddr = col_addr;

  svmm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_COLUMNS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An entry counts only when it was written under the current job tag.
  assign hit       = col_ok_r && (ram_rdata[WORD_W-1:VAL_W] == epoch_r);
  assign product   = value_r * ram_rdata[VAL_W-1:0];
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
      epoch_r      <= EPOCH_FIRST;
      acc_r        <= '0;
      row_r        <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.sweep_wr) begin
        sweep_addr_r <= status.sweep_last ? '0 : sweep_addr_r + AW'(1);
      end
      if (cmd.clear) begin
        acc_r        <= '0;
        row_r        <= '0;
        count_r      <= '0;
        sweep_addr_r <= '0;
        epoch_r      <= (epoch_r == EPOCH_LAST) ? EPOCH_FIRST : epoch_r + EPOCH_W'(1);
      end
      if (cmd.acc_add) begin
        acc_r <= acc_r + prod_r;
      end
      if (cmd.row_done) begin
        acc_r <= '0;
        row_r <= row_r + ROW_W'(1);
      end
      if (cmd.emit_row) begin
        count_r <= count_inc;
      end
      if (cmd.emit_row || cmd.emit_job) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r  <= in_value;
      col_ok_r <= col_ok;
    end
    if (cmd.mul) begin
      prod_r <= hit ? product : '0;
    end
    if (cmd.emit_row) begin
      out_kind         <= KIND_ROW;
      out_row_index    <= row_r;
      out_sum          <= acc_r;
      out_status       <= 1'b0;
      out_result_count <= count_inc;
    end else if (cmd.emit_job) begin
      out_kind         <= KIND_JOB;
      out_row_index    <= row_r;
      out_sum          <= '0;
      out_status       <= (count_r == '0);
      out_result_count <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign status.out_free   = !out_valid_r || out_ready;
  assign status.acc_nz     = (acc_r != '0);
  assign status.epoch_last = (epoch_r == EPOCH_LAST);
  assign status.sweep_last = (sweep_addr_r == AW'(MAX_COLUMNS - 1));

endmodule
